// ===== rtl/length_prefixed_message_deframer_core_assert.svh =====
// Assertion macros for the deframer RTL.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define LPMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== rtl/lpmd_pkg.sv =====
// Types and constants of the length-prefixed message deframer.
package lpmd_pkg;

  typedef enum logic [1:0] {
    ST_NEED_MORE  = 2'd0,
    ST_READY      = 2'd1,
    ST_COMPRESSED = 2'd2,
    ST_OVERSIZE   = 2'd3
  } status_e;

  localparam int unsigned CFG_W        = 17;
  localparam int unsigned OFFSET_W     = 16;
  localparam int unsigned MLEN_W       = 17;
  localparam int unsigned LEN_W        = 32;
  localparam logic [2:0]  HDR_FIRST    = 3'd0;
  localparam logic [2:0]  HDR_LAST     = 3'd4;
  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;
  localparam int unsigned FIFO_DEPTH   = 2;

  typedef struct packed {
    logic       valid;
    logic [7:0] in_byte;
  } head_t;

  typedef struct packed {
    logic                accepted;
    status_e             frame_status;
    logic                is_payload;
    logic [7:0]          payload_byte;
    logic [OFFSET_W-1:0] payload_offset;
    logic [MLEN_W-1:0]   message_length;
  } result_t;

endpackage

// ===== rtl/length_prefixed_message_deframer_core.sv =====
// Top level of the length-prefixed message deframer: input queue plus deframing engine.
// Each accepted byte gives one result item: the byte is held in the input queue, then the engine
// takes it from the queue head and registers its result in the output result register.
// Throughput is one byte per cycle unless the output stalls, set by the header/payload update.
// Asynchronous active-low reset empties the queue, clears all framing state and the
// poison flag, and sets the maximum message length register to 65536.
module length_prefixed_message_deframer_core #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,   // max_message_len
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [2:1] frame_status, [10:3] payload_byte,
  // [26:11] payload_offset, [43:27] message_length, [47:44] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser   // [0] is_payload
);
  import lpmd_pkg::*;

  head_t   head;
  logic    pop;
  result_t result;

  lpmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .ready_o (s_axis_tready),
    .pop_i   (pop),
    .head_o  (head)
  );

  lpmd_engine #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {4'd0, result.message_length, result.payload_offset,
                         result.payload_byte, result.frame_status, result.accepted};
  assign m_axis_tuser = result.is_payload;

endmodule

// ===== rtl/lpmd_fifo.sv =====
// Front queue: accepts input bytes and holds them for the deframing engine.
module lpmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output lpmd_pkg::head_t   head_o
);
  import lpmd_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [7:0]       slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(FIFO_DEPTH));
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.valid   = (count_q != '0);
  assign head_o.in_byte = slot_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lpmd_engine.sv =====
// Back end: header parsing, payload tracking, sticky errors and the result register.
module lpmd_engine #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpmd_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  lpmd_pkg::head_t              head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lpmd_pkg::result_t            result_o
);
  import lpmd_pkg::*;
  `include "length_prefixed_message_deframer_core_assert.svh"

  localparam int unsigned FILL_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE_BYTES);

  logic [CFG_W-1:0]  max_len_q;
  logic [2:0]        hdr_cnt_q, hdr_cnt_d;
  logic [7:0]        flag_q, flag_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              in_payload_q, in_payload_d;
  logic [FILL_W-1:0] filled_q, filled_d;
  logic              poisoned_q, poisoned_d;
  logic              out_valid_q;
  result_t           res_q, res_d;

  logic [LEN_W-1:0]  cap;
  logic [LEN_W-1:0]  cfg_ext;
  logic [LEN_W-1:0]  new_len;
  logic [LEN_W-1:0]  filled_ext;
  logic [LEN_W-1:0]  filled_inc;

  assign pop_o       = head_i.valid && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign cfg_ext    = LEN_W'(max_len_q);
  assign cap        = (cfg_ext < MAX_LEN) ? cfg_ext : MAX_LEN;
  assign new_len    = {len_q[LEN_W-9:0], head_i.in_byte};
  assign filled_ext = LEN_W'(filled_q);
  assign filled_inc = filled_ext + LEN_W'(1);

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    flag_d       = flag_q;
    len_d        = len_q;
    in_payload_d = in_payload_q;
    filled_d     = filled_q;
    poisoned_d   = poisoned_q;

    res_d.accepted       = 1'b1;
    res_d.frame_status   = ST_NEED_MORE;
    res_d.is_payload     = 1'b0;
    res_d.payload_byte   = '0;
    res_d.payload_offset = '0;
    res_d.message_length = '0;

    if (poisoned_q) begin
      res_d.accepted     = 1'b0;
      res_d.frame_status = ST_OVERSIZE;
    end else if (!in_payload_q) begin
      if (hdr_cnt_q == HDR_FIRST) begin
        flag_d    = head_i.in_byte;
        hdr_cnt_d = 3'd1;
      end else begin
        len_d = new_len;
        if (hdr_cnt_q != HDR_LAST) begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else begin
          hdr_cnt_d = HDR_FIRST;
          // The flag is checked before the length.
          priority if (flag_q != 8'd0) begin
            poisoned_d         = 1'b1;
            res_d.frame_status = ST_COMPRESSED;
          end else if (new_len > cap) begin
            poisoned_d         = 1'b1;
            res_d.frame_status = ST_OVERSIZE;
          end else if (new_len == '0) begin
            res_d.frame_status = ST_READY;
          end else begin
            in_payload_d         = 1'b1;
            filled_d             = '0;
            res_d.message_length = new_len[MLEN_W-1:0];
          end
        end
      end
    end else begin
      res_d.is_payload     = 1'b1;
      res_d.payload_byte   = head_i.in_byte;
      res_d.payload_offset = filled_ext[OFFSET_W-1:0];
      res_d.message_length = len_q[MLEN_W-1:0];
      filled_d             = filled_inc[FILL_W-1:0];
      if (filled_inc >= len_q) begin
        in_payload_d       = 1'b0;
        filled_d           = '0;
        res_d.frame_status = ST_READY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= CFG_RESET;
      hdr_cnt_q    <= HDR_FIRST;
      flag_q       <= '0;
      len_q        <= '0;
      in_payload_q <= 1'b0;
      filled_q     <= '0;
      poisoned_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        hdr_cnt_q    <= hdr_cnt_d;
        flag_q       <= flag_d;
        len_q        <= len_d;
        in_payload_q <= in_payload_d;
        filled_q     <= filled_d;
        poisoned_q   <= poisoned_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  // Once poisoned, every byte taken from the queue reports a refused oversize result.
  `LPMD_ASSERT_NEXT(a_poison_refuses, pop_o && poisoned_q,
                    out_valid_q && !res_q.accepted && res_q.frame_status == ST_OVERSIZE)
  // Header collection and payload tracking never overlap.
  `LPMD_ASSERT_IMPL(a_payload_no_header, in_payload_q, hdr_cnt_q == HDR_FIRST)
  // The payload counter stays below the message length.
  `LPMD_ASSERT_IMPL(a_fill_below_len, in_payload_q, filled_ext < len_q)
  // The poison flag never clears outside reset.
  `LPMD_ASSERT_NEXT(a_poison_sticky, poisoned_q, poisoned_q)

endmodule
